// File: hw/rtl/i2c_master_bit_sequencer_top_defines.svh
`ifndef I2C_MASTER_BIT_SEQUENCER_TOP_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define I2CMS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("i2cms assertion failed");

`define I2CMS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("i2cms assertion failed");

`define I2CMS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("i2cms assertion failed");

`else

`define I2CMS_ASSERT(name, prop)
`define I2CMS_ASSERT_IMP(name, ante, cons)
`define I2CMS_ASSERT_NXT(name, ante, cons)

`endif

`endif

// File: hw/rtl/i2cms_pkg.sv
package i2cms_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;

  localparam int unsigned ActW   = 3;
  localparam int unsigned PhaseW = 5;
  localparam int unsigned TicksW = 10;

  localparam logic [ActW-1:0] ACT_TICK  = 3'd0;
  localparam logic [ActW-1:0] ACT_START = 3'd1;
  localparam logic [ActW-1:0] ACT_STOP  = 3'd2;
  localparam logic [ActW-1:0] ACT_WRITE = 3'd3;
  localparam logic [ActW-1:0] ACT_READ  = 3'd4;

  localparam logic [ActW-1:0] OP_IDLE  = ACT_TICK;
  localparam logic [ActW-1:0] OP_START = ACT_START;
  localparam logic [ActW-1:0] OP_STOP  = ACT_STOP;
  localparam logic [ActW-1:0] OP_WRITE = ACT_WRITE;
  localparam logic [ActW-1:0] OP_READ  = ACT_READ;

  localparam logic [PhaseW-1:0] START_PHASES = PhaseW'(4);
  localparam logic [PhaseW-1:0] STOP_PHASES  = PhaseW'(3);
  localparam logic [PhaseW-1:0] WRITE_PHASES = PhaseW'(3 * BITS_PER_BYTE + 4);
  localparam logic [PhaseW-1:0] READ_PHASES  = PhaseW'(2 * BITS_PER_BYTE + 5);

  localparam logic [TicksW-1:0] PHASE_TICKS_RST = TicksW'(5);

  typedef struct packed {
    logic [ActW-1:0]          action;
    logic [BITS_PER_BYTE-1:0] data_byte;
    logic                     send_nack;
    logic                     sda_in;
  } item_t;

  typedef struct packed {
    logic                     scl;
    logic                     sda;
    logic                     released;
    logic                     busy;
    logic                     done;
    logic [BITS_PER_BYTE-1:0] read_data;
    logic                     nack;
    logic                     rejected;
  } res_t;

  function automatic logic [PhaseW-1:0] phase_total(logic [ActW-1:0] op);
    logic [PhaseW-1:0] n;
    unique case (op)
      OP_START: n = START_PHASES;
      OP_STOP:  n = STOP_PHASES;
      OP_WRITE: n = WRITE_PHASES;
      OP_READ:  n = READ_PHASES;
      default:  n = '0;
    endcase
    return n;
  endfunction

endpackage

// File: hw/rtl/i2c_master_bit_sequencer_top.sv
// I2C master bit sequencer: one command (start, stop, write byte, read byte) runs at a time
// as a series of SCL/SDA phases, each lasting cfg_data_i ticks (0 counts as 1), and tick
// requests advance it. Every accepted request yields exactly one result, held first in the
// input register and then in the result register before it is presented. A new request is
// taken every clock as long as the output side keeps taking results. Commands sent while busy
// come back with rejected set.
// Write the phase length only while the block is idle.
`include "i2c_master_bit_sequencer_top_defines.svh"

module i2c_master_bit_sequencer_top import i2cms_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ActW-1:0]          action_i,
  input  logic [BITS_PER_BYTE-1:0] data_byte_i,
  input  logic                     send_nack_i,
  input  logic                     sda_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     scl_level_o,
  output logic                     sda_level_o,
  output logic                     sda_released_o,
  output logic                     busy_res_o,
  output logic                     done_res_o,
  output logic [BITS_PER_BYTE-1:0] read_data_o,
  output logic                     nack_received_o,
  output logic                     rejected_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [TicksW-1:0]        cfg_data_i
);

  logic              in_vld_q, in_vld_d;
  item_t             item_q;
  logic              out_vld_q, out_vld_d;
  res_t              res_q, res_d;
  logic [TicksW-1:0] ticks_q;
  logic              accept, step;

  assign accept     = in_valid_i && !in_stall_o;
  assign step       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !step;
  assign in_vld_d   = accept || (in_vld_q && !step);
  assign out_vld_d  = step || (out_vld_q && out_stall_i);
  assign cfg_ready_o = 1'b1;

  i2cms_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .item_i        (item_q),
    .phase_ticks_i (ticks_q),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      ticks_q   <= PHASE_TICKS_RST;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) ticks_q <= cfg_data_i;
    end
  end

  // request payload and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.action    <= action_i;
      item_q.data_byte <= data_byte_i;
      item_q.send_nack <= send_nack_i;
      item_q.sda_in    <= sda_in_i;
    end
    if (step) res_q <= res_d;
  end

  assign out_valid_o     = out_vld_q;
  assign scl_level_o     = res_q.scl;
  assign sda_level_o     = res_q.sda;
  assign sda_released_o  = res_q.released;
  assign busy_res_o      = res_q.busy;
  assign done_res_o      = res_q.done;
  assign read_data_o     = res_q.read_data;
  assign nack_received_o = res_q.nack;
  assign rejected_o      = res_q.rejected;

  `I2CMS_ASSERT_IMP(a_stall_needs_item, in_stall_o, in_vld_q && out_vld_q)
  `I2CMS_ASSERT_NXT(a_step_gives_result, step, out_vld_q)
  `I2CMS_ASSERT_NXT(a_held_result_stable, out_vld_q && out_stall_i, out_vld_q && $stable(res_q))

endmodule

// File: hw/rtl/i2cms_core.sv
`include "i2c_master_bit_sequencer_top_defines.svh"

module i2cms_core import i2cms_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  item_t             item_i,
  input  logic [TicksW-1:0] phase_ticks_i,
  output res_t              res_o
);

  localparam logic [PhaseW-1:0] WR_DATA_END = PhaseW'(3 * BITS_PER_BYTE);
  localparam logic [PhaseW-1:0] WR_ACK_HI   = PhaseW'(3 * BITS_PER_BYTE + 2);
  localparam logic [PhaseW-1:0] WR_ACK_LO   = PhaseW'(3 * BITS_PER_BYTE + 3);
  localparam logic [PhaseW-1:0] RD_BITS_END = PhaseW'(2 * BITS_PER_BYTE);
  localparam logic [PhaseW-1:0] RD_ACK_LO   = PhaseW'(2 * BITS_PER_BYTE + 1);
  localparam logic [PhaseW-1:0] RD_ACK_SET  = PhaseW'(2 * BITS_PER_BYTE + 2);
  localparam logic [PhaseW-1:0] RD_ACK_HI   = PhaseW'(2 * BITS_PER_BYTE + 3);

  typedef struct packed {
    logic                     scl;
    logic                     sda;
    logic                     rel;
    logic                     ack;
    logic                     nack_tx;
    logic [BITS_PER_BYTE-1:0] shift;
  } seq_t;

  logic [ActW-1:0]          op_q, op_d;
  logic [PhaseW-1:0]        idx_q, idx_d;
  logic [1:0]               rem_q, rem_d;
  logic [TicksW-1:0]        tick_q, tick_d;
  seq_t                     seq_q, seq_d;
  logic [BITS_PER_BYTE-1:0] rd_q, rd_d;
  logic                     done, rej;

  function automatic seq_t enter_phase(logic [ActW-1:0] op, logic [PhaseW-1:0] idx,
                                       logic [1:0] rem, seq_t s);
    seq_t r;
    r = s;
    unique case (op)
      OP_START: begin
        unique case (idx)
          PhaseW'(0): r.scl = 1'b1;
          PhaseW'(1): r.sda = 1'b1;
          PhaseW'(2): r.sda = 1'b0;
          default:    r.scl = 1'b0;
        endcase
      end
      OP_STOP: begin
        unique case (idx)
          PhaseW'(0): r.sda = 1'b0;
          PhaseW'(1): r.scl = 1'b1;
          default:    r.sda = 1'b1;
        endcase
      end
      OP_WRITE: begin
        priority if (idx < WR_DATA_END) begin
          unique case (rem)
            2'd0: r.scl = 1'b0;
            2'd1: begin
              r.sda   = s.shift[BITS_PER_BYTE-1];
              r.shift = {s.shift[BITS_PER_BYTE-2:0], 1'b0};
            end
            default: r.scl = 1'b1;
          endcase
        end else if (idx == WR_ACK_HI) begin
          r.rel = 1'b1;
          r.scl = 1'b1;
        end else begin
          r.scl = 1'b0;
        end
      end
      OP_READ: begin
        priority if (idx == '0) begin
          r.scl = 1'b0;
        end else if (idx <= RD_BITS_END) begin
          if (idx[0]) begin
            r.rel = 1'b1;
            r.scl = 1'b1;
          end else begin
            r.scl = 1'b0;
          end
        end else if (idx == RD_ACK_LO) begin
          r.rel = 1'b0;
          r.scl = 1'b0;
        end else if (idx == RD_ACK_SET) begin
          r.sda = s.nack_tx;
        end else if (idx == RD_ACK_HI) begin
          r.scl = 1'b1;
        end else begin
          r.scl = 1'b0;
        end
      end
      default: r = s;
    endcase
    return r;
  endfunction

  always_comb begin
    logic [TicksW-1:0] limit;
    logic [TicksW-1:0] tnext;
    logic [PhaseW-1:0] inext;
    logic [1:0]        rnext;
    op_d   = op_q;
    idx_d  = idx_q;
    rem_d  = rem_q;
    tick_d = tick_q;
    seq_d  = seq_q;
    rd_d   = rd_q;
    done   = 1'b0;
    rej    = 1'b0;
    limit  = (phase_ticks_i == '0) ? TicksW'(1) : phase_ticks_i;
    tnext  = tick_q + TicksW'(1);
    inext  = idx_q + PhaseW'(1);
    rnext  = (rem_q == 2'd2) ? 2'd0 : rem_q + 2'd1;
    if (item_i.action == ACT_TICK) begin
      if (op_q != OP_IDLE) begin
        if (tnext >= limit) begin
          // sampling at the end of the phase
          if (op_q == OP_WRITE) begin
            if (idx_q == WR_ACK_HI) seq_d.ack = item_i.sda_in;
            else if (idx_q == WR_ACK_LO) seq_d.rel = 1'b0;
          end else if (op_q == OP_READ) begin
            if (idx_q != '0 && idx_q < RD_BITS_END && idx_q[0]) begin
              seq_d.shift = {seq_q.shift[BITS_PER_BYTE-2:0], item_i.sda_in};
            end
          end
          tick_d = '0;
          if (inext >= phase_total(op_q)) begin
            if (op_q == OP_READ) rd_d = seq_d.shift;
            op_d  = OP_IDLE;
            idx_d = '0;
            rem_d = '0;
            done  = 1'b1;
          end else begin
            idx_d = inext;
            rem_d = rnext;
            seq_d = enter_phase(op_q, inext, rnext, seq_d);
          end
        end else begin
          tick_d = tnext;
        end
      end
    end else if (item_i.action <= ACT_READ) begin
      if (op_q != OP_IDLE) begin
        rej = 1'b1;
      end else begin
        op_d   = item_i.action;
        idx_d  = '0;
        rem_d  = '0;
        tick_d = '0;
        if (item_i.action == ACT_WRITE) seq_d.shift = item_i.data_byte;
        if (item_i.action == ACT_READ) seq_d.nack_tx = item_i.send_nack;
        seq_d = enter_phase(item_i.action, '0, 2'd0, seq_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q          <= OP_IDLE;
      idx_q         <= '0;
      rem_q         <= '0;
      tick_q        <= '0;
      seq_q.scl     <= 1'b1;
      seq_q.sda     <= 1'b1;
      seq_q.rel     <= 1'b0;
      seq_q.ack     <= 1'b0;
      seq_q.nack_tx <= 1'b0;
      seq_q.shift   <= '0;
      rd_q          <= '0;
    end else if (step_i) begin
      op_q   <= op_d;
      idx_q  <= idx_d;
      rem_q  <= rem_d;
      tick_q <= tick_d;
      seq_q  <= seq_d;
      rd_q   <= rd_d;
    end
  end

  assign res_o.scl       = seq_d.scl;
  assign res_o.sda       = seq_d.sda;
  assign res_o.released  = seq_d.rel;
  assign res_o.busy      = (op_d != OP_IDLE);
  assign res_o.done      = done;
  assign res_o.read_data = rd_d;
  assign res_o.nack      = seq_d.ack;
  assign res_o.rejected  = rej;

  `I2CMS_ASSERT_IMP(a_idle_counters_clear, op_q == OP_IDLE, idx_q == '0 && tick_q == '0)
  `I2CMS_ASSERT_NXT(a_done_goes_idle, step_i && done, op_q == OP_IDLE)
  `I2CMS_ASSERT_NXT(a_reject_holds_time, step_i && rej, $stable(idx_q) && $stable(tick_q))
  `I2CMS_ASSERT_IMP(a_done_not_busy, done, !res_o.busy && !rej)

endmodule
